### hdl/kfcv_pkg.sv
// Package for the constant-velocity Kalman filter.
// Holds the sequencer state type, unit status struct and fault and register codes.
// No dependencies.
package kfcv_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SVAR,
        ST_INNOV,
        ST_DIV0,
        ST_DIV1,
        ST_MUL,
        ST_PRED,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic done;
        logic clamp;
    } t_unit_status;

    localparam logic [1:0] FAULT_OK      = 2'd0;
    localparam logic [1:0] FAULT_SKIPPED = 2'd1;
    localparam logic [1:0] FAULT_SAT     = 2'd2;

    localparam int CFG_INDEX_WIDTH = 4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MEAS_NOISE = 4'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_Q_PP       = 4'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_Q_PV       = 4'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_Q_VP       = 4'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_Q_VV       = 4'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MOTION_POS = 4'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MOTION_VEL = 4'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INIT_VAR   = 4'd7;

    localparam logic [2:0] MUL_OP_LAST = 3'd5;

endpackage

### hdl/kfcv_mul.sv
// Bit-serial fixed-point multiplier: one multiplier bit per cycle.
// Depends on kfcv_pkg for the status struct.
module kfcv_mul import kfcv_pkg::*; #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [WORD_WIDTH-1:0] i_a,
    input  logic signed [WORD_WIDTH-1:0] i_b,
    output logic signed [WORD_WIDTH-1:0] o_result,
    output t_unit_status                 o_status
);
    localparam int W  = WORD_WIDTH;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]    r_mc;
    logic [W-1:0]    r_mp;
    logic [W-1:0]    r_hi;
    logic            r_neg;
    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    logic [W:0]      n_sum;
    logic [2*W-1:0]  n_prod;
    logic [2*W-1:0]  n_shift;
    logic [2*W-1:0]  n_lim;
    logic [2*W-1:0]  n_mag;
    logic            n_clamp;

    assign n_sum = {1'b0, r_hi} + (r_mp[0] ? {1'b0, r_mc} : {(W+1){1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_mc   <= i_a[W-1] ? (~i_a + 1'b1) : i_a;
                r_mp   <= i_b[W-1] ? (~i_b + 1'b1) : i_b;
                r_hi   <= '0;
                r_neg  <= i_a[W-1] ^ i_b[W-1];
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_hi  <= n_sum[W:1];
                r_mp  <= {n_sum[0], r_mp[W-1:1]};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The magnitude is clamped against 2^(W-1) for negative results and one less otherwise.
    always_comb begin
        n_prod  = {r_hi, r_mp};
        n_shift = n_prod >> FRAC_BITS;
        n_lim   = (2*W)'(1) << (W - 1);
        if (!r_neg) begin
            n_lim = n_lim - 1'b1;
        end
        n_clamp  = n_shift > n_lim;
        n_mag    = n_clamp ? n_lim : n_shift;
        o_result = r_neg ? (~n_mag[W-1:0] + 1'b1) : n_mag[W-1:0];
    end

    assign o_status.done  = r_done;
    assign o_status.clamp = n_clamp;

endmodule

### hdl/kfcv_div.sv
// Bit-serial restoring divider for fixed-point gains: one quotient bit per cycle.
// Depends on kfcv_pkg for the status struct. The divisor must be positive.
module kfcv_div import kfcv_pkg::*; #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [WORD_WIDTH-1:0] i_a,
    input  logic signed [WORD_WIDTH-1:0] i_b,
    output logic signed [WORD_WIDTH-1:0] o_result,
    output t_unit_status                 o_status
);
    localparam int W  = WORD_WIDTH;
    localparam int N  = WORD_WIDTH + FRAC_BITS;
    localparam int CW = $clog2(N + 1);

    logic [N-1:0]  r_dv;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_den;
    logic          r_neg;
    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W:0]    n_trial;
    logic [W:0]    n_diff;
    logic          n_qbit;
    logic [W-1:0]  n_mag_a;
    logic [N-1:0]  n_lim;
    logic [N-1:0]  n_mag;
    logic          n_clamp;

    assign n_mag_a = i_a[W-1] ? (~i_a + 1'b1) : i_a;
    assign n_trial = {r_rem, r_dv[N-1]};
    assign n_diff  = n_trial - {1'b0, r_den};
    assign n_qbit  = n_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_dv   <= {n_mag_a, {FRAC_BITS{1'b0}}};
                r_rem  <= '0;
                r_den  <= i_b;
                r_neg  <= i_a[W-1];
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_qbit ? n_diff[W-1:0] : n_trial[W-1:0];
                r_dv  <= {r_dv[N-2:0], n_qbit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(N - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_lim = N'(1) << (W - 1);
        if (!r_neg) begin
            n_lim = n_lim - 1'b1;
        end
        n_clamp  = r_dv > n_lim;
        n_mag    = n_clamp ? n_lim : r_dv;
        o_result = r_neg ? (~n_mag[W-1:0] + 1'b1) : n_mag[W-1:0];
    end

    assign o_status.done  = r_done;
    assign o_status.clamp = n_clamp;

endmodule

### hdl/kalman_filter_const_velocity.sv
// Each measurement update runs through the bit-serial divider (two gains) and multiplier (six
// products) in turn; the next sample is taken once the sequencer is idle, even while the
// previous result still waits in the output register.
// Reset (synchronous, active low) loads zero state, init_var covariance and register defaults.
module kalman_filter_const_velocity import kfcv_pkg::*; #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [WORD_WIDTH-1:0] i_measured_pos,
    input  logic                         i_restart,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [WORD_WIDTH-1:0] o_est_pos,
    output logic signed [WORD_WIDTH-1:0] o_est_vel,
    output logic signed [WORD_WIDTH-1:0] o_cov_out_pp,
    output logic signed [WORD_WIDTH-1:0] o_cov_out_pv,
    output logic signed [WORD_WIDTH-1:0] o_cov_out_vp,
    output logic signed [WORD_WIDTH-1:0] o_cov_out_vv,
    output logic [1:0]                   o_fault,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]   i_cfg_index,
    input  logic [WORD_WIDTH-1:0]        i_cfg_data
);
    localparam int W  = WORD_WIDTH;
    localparam int XW = WORD_WIDTH + 3;
    // Sums are formed exactly three bits wider and then clamped to the word range.
    localparam logic signed [XW-1:0] SAT_MAX = {4'b0000, {(W-1){1'b1}}};
    localparam logic signed [XW-1:0] SAT_MIN = ~SAT_MAX;
    localparam logic [W-2:0] MEAS_NOISE_RESET = (W-1)'(65536);
    localparam logic [W-2:0] INIT_VAR_RESET   = (W-1)'(65536000);

    function automatic logic signed [W-1:0] clip(input logic signed [XW-1:0] v);
        if (v > SAT_MAX) begin
            return SAT_MAX[W-1:0];
        end else if (v < SAT_MIN) begin
            return SAT_MIN[W-1:0];
        end
        return v[W-1:0];
    endfunction

    function automatic logic over(input logic signed [XW-1:0] v);
        return (v > SAT_MAX) || (v < SAT_MIN);
    endfunction

    function automatic logic signed [XW-1:0] ext(input logic signed [W-1:0] v);
        return XW'(v);
    endfunction

    // Configuration registers.
    logic [W-2:0]        r_meas_noise;
    logic signed [W-1:0] r_q_pp, r_q_pv, r_q_vp, r_q_vv;
    logic signed [W-1:0] r_motion_pos, r_motion_vel;
    logic [W-2:0]        r_init_var;

    // Filter state and per-sample working values.
    logic signed [W-1:0] r_pos, r_vel, r_p00, r_p01, r_p10, r_p11;
    logic signed [W-1:0] r_z, r_s, r_y, r_k0, r_k1;
    logic                r_clamp;
    logic                r_skip;
    logic                r_launch;
    logic [2:0]          r_op;
    t_state              r_state;
    t_state              n_state;

    // Output register.
    logic                r_out_valid;
    logic signed [W-1:0] r_o_pos, r_o_vel, r_o_pp, r_o_pv, r_o_vp, r_o_vv;
    logic [1:0]          r_o_fault;

    logic                in_xfer;
    logic                div_start, mul_start;
    logic signed [W-1:0] div_a, div_q, mul_a, mul_b, mul_p;
    t_unit_status        div_st, mul_st;

    logic signed [XW-1:0] n_svar, n_innov;
    logic signed [XW-1:0] n_comb;
    logic signed [W-1:0]  n_base;
    logic                 n_sub;
    logic signed [XW-1:0] n_pr_pos, n_pr_vel, n_pr_00, n_pr_01, n_pr_10, n_pr_11;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meas_noise <= MEAS_NOISE_RESET;
            r_q_pp       <= '0;
            r_q_pv       <= '0;
            r_q_vp       <= '0;
            r_q_vv       <= '0;
            r_motion_pos <= '0;
            r_motion_vel <= '0;
            r_init_var   <= INIT_VAR_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MEAS_NOISE: r_meas_noise <= i_cfg_data[W-2:0];
                REG_Q_PP:       r_q_pp       <= i_cfg_data;
                REG_Q_PV:       r_q_pv       <= i_cfg_data;
                REG_Q_VP:       r_q_vp       <= i_cfg_data;
                REG_Q_VV:       r_q_vv       <= i_cfg_data;
                REG_MOTION_POS: r_motion_pos <= i_cfg_data;
                REG_MOTION_VEL: r_motion_vel <= i_cfg_data;
                REG_INIT_VAR:   r_init_var   <= i_cfg_data[W-2:0];
                default: ;
            endcase
        end
    end

    // Shared serial units: the divider forms both gains, the multiplier all six products.
    assign div_a     = (r_state == ST_DIV0) ? r_p00 : r_p10;
    assign div_start = ((r_state == ST_DIV0) || (r_state == ST_DIV1)) && !r_launch;
    assign mul_start = (r_state == ST_MUL) && !r_launch;

    kfcv_div #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_a      (div_a),
        .i_b      (r_s),
        .o_result (div_q),
        .o_status (div_st)
    );

    kfcv_mul #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_a      (mul_a),
        .i_b      (mul_b),
        .o_result (mul_p),
        .o_status (mul_st)
    );

    // Measurement update order keeps every operand unchanged until its last use:
    // the gains times the innovation go to position and velocity, then the covariance
    // is corrected from the bottom-right entry up to the top-left one.
    always_comb begin
        mul_a  = r_k0;
        mul_b  = r_y;
        n_base = r_pos;
        n_sub  = 1'b0;
        case (r_op)
            3'd0: begin mul_a = r_k0; mul_b = r_y;   n_base = r_pos; n_sub = 1'b0; end
            3'd1: begin mul_a = r_k1; mul_b = r_y;   n_base = r_vel; n_sub = 1'b0; end
            3'd2: begin mul_a = r_k1; mul_b = r_p01; n_base = r_p11; n_sub = 1'b1; end
            3'd3: begin mul_a = r_k0; mul_b = r_p01; n_base = r_p01; n_sub = 1'b1; end
            3'd4: begin mul_a = r_k1; mul_b = r_p00; n_base = r_p10; n_sub = 1'b1; end
            default: begin mul_a = r_k0; mul_b = r_p00; n_base = r_p00; n_sub = 1'b1; end
        endcase
        n_comb = n_sub ? (ext(n_base) - ext(mul_p)) : (ext(n_base) + ext(mul_p));
    end

    assign n_svar  = ext(r_p00) + XW'(r_meas_noise);
    assign n_innov = ext(r_z) - ext(r_pos);

    // Prediction with F = [[1,1],[0,1]]: all terms use the state after any correction.
    assign n_pr_pos = ext(r_pos) + ext(r_vel) + ext(r_motion_pos);
    assign n_pr_vel = ext(r_vel) + ext(r_motion_vel);
    assign n_pr_00  = ext(r_p00) + ext(r_p01) + ext(r_p10) + ext(r_p11) + ext(r_q_pp);
    assign n_pr_01  = ext(r_p01) + ext(r_p11) + ext(r_q_pv);
    assign n_pr_10  = ext(r_p10) + ext(r_p11) + ext(r_q_vp);
    assign n_pr_11  = ext(r_p11) + ext(r_q_vv);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_xfer) begin n_state = ST_SVAR; end
            ST_SVAR:  n_state = (clip(n_svar) <= 0) ? ST_PRED : ST_INNOV;
            ST_INNOV: n_state = ST_DIV0;
            ST_DIV0:  if (div_st.done) begin n_state = ST_DIV1; end
            ST_DIV1:  if (div_st.done) begin n_state = ST_MUL; end
            ST_MUL:   if (mul_st.done && (r_op == MUL_OP_LAST)) begin n_state = ST_PRED; end
            ST_PRED:  n_state = ST_DONE;
            ST_DONE:  if (!r_out_valid || i_out_ready) begin n_state = ST_IDLE; end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_launch    <= 1'b0;
            r_op        <= '0;
            r_out_valid <= 1'b0;
            r_clamp     <= 1'b0;
            r_skip      <= 1'b0;
            r_pos       <= '0;
            r_vel       <= '0;
            r_p00       <= W'(INIT_VAR_RESET);
            r_p01       <= '0;
            r_p10       <= '0;
            r_p11       <= W'(INIT_VAR_RESET);
        end else begin
            r_state <= n_state;
            // A new result loads the output register in the same cycle the old one leaves.
            if ((r_state == ST_DONE) && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (div_start || mul_start) begin
                r_launch <= 1'b1;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_z     <= i_measured_pos;
                        r_clamp <= 1'b0;
                        r_skip  <= 1'b0;
                        r_op    <= '0;
                        if (i_restart) begin
                            r_pos <= '0;
                            r_vel <= '0;
                            r_p00 <= W'(r_init_var);
                            r_p01 <= '0;
                            r_p10 <= '0;
                            r_p11 <= W'(r_init_var);
                        end
                    end
                end
                ST_SVAR: begin
                    r_s    <= clip(n_svar);
                    r_skip <= clip(n_svar) <= 0;
                    if (over(n_svar)) begin
                        r_clamp <= 1'b1;
                    end
                end
                ST_INNOV: begin
                    r_y <= clip(n_innov);
                    if (over(n_innov)) begin
                        r_clamp <= 1'b1;
                    end
                end
                ST_DIV0, ST_DIV1: begin
                    if (div_st.done) begin
                        r_launch <= 1'b0;
                        if (div_st.clamp) begin
                            r_clamp <= 1'b1;
                        end
                        if (r_state == ST_DIV0) begin
                            r_k0 <= div_q;
                        end else begin
                            r_k1 <= div_q;
                        end
                    end
                end
                ST_MUL: begin
                    if (mul_st.done) begin
                        r_launch <= 1'b0;
                        r_op     <= r_op + 1'b1;
                        if (mul_st.clamp || over(n_comb)) begin
                            r_clamp <= 1'b1;
                        end
                        case (r_op)
                            3'd0:    r_pos <= clip(n_comb);
                            3'd1:    r_vel <= clip(n_comb);
                            3'd2:    r_p11 <= clip(n_comb);
                            3'd3:    r_p01 <= clip(n_comb);
                            3'd4:    r_p10 <= clip(n_comb);
                            default: r_p00 <= clip(n_comb);
                        endcase
                    end
                end
                ST_PRED: begin
                    r_pos <= clip(n_pr_pos);
                    r_vel <= clip(n_pr_vel);
                    r_p00 <= clip(n_pr_00);
                    r_p01 <= clip(n_pr_01);
                    r_p10 <= clip(n_pr_10);
                    r_p11 <= clip(n_pr_11);
                    if (over(n_pr_pos) || over(n_pr_vel) || over(n_pr_00) ||
                        over(n_pr_01) || over(n_pr_10) || over(n_pr_11)) begin
                        r_clamp <= 1'b1;
                    end
                end
                ST_DONE: begin
                    // The result moves into the output register once it is free.
                    if (!r_out_valid || i_out_ready) begin
                        r_o_pos     <= r_pos;
                        r_o_vel     <= r_vel;
                        r_o_pp      <= r_p00;
                        r_o_pv      <= r_p01;
                        r_o_vp      <= r_p10;
                        r_o_vv      <= r_p11;
                        r_o_fault   <= r_skip ? FAULT_SKIPPED :
                                       (r_clamp ? FAULT_SAT : FAULT_OK);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_est_pos    = r_o_pos;
    assign o_est_vel    = r_o_vel;
    assign o_cov_out_pp = r_o_pp;
    assign o_cov_out_pv = r_o_pv;
    assign o_cov_out_vp = r_o_vp;
    assign o_cov_out_vv = r_o_vv;
    assign o_fault      = r_o_fault;

endmodule

### tb/sv/kalman_filter_const_velocity_tb.sv
// Self-checking testbench for the constant-velocity Kalman filter.
// Depends on kfcv_pkg and the kalman_filter_const_velocity block; a scoreboard class tracks
// the filter state in saturating fixed point and checks every output transfer.
module kalman_filter_const_velocity_tb;
    import kfcv_pkg::*;

    localparam int WW          = 32;
    localparam int FB          = 16;
    localparam int STALL_LIMIT = 4000;  // cycles with no transfer on any channel
    localparam int SETTLE      = 400;   // a bit more than one sample latency
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FIRST_UNUSED = REG_INIT_VAR + 1;

    typedef struct packed {
        logic [WW-1:0] pos;
        logic [WW-1:0] vel;
        logic [WW-1:0] pp;
        logic [WW-1:0] pv;
        logic [WW-1:0] vp;
        logic [WW-1:0] vv;
        logic [1:0]    fault;
    } t_estimate;

    // Filter state and registers kept in 64-bit signed integers; every step result is
    // clamped back to the 32-bit range exactly as the block should do it.
    class filter_scoreboard;
        longint r_meas, q_pp, q_pv, q_vp, q_vv, mot_pos, mot_vel, init_var;
        longint pos, vel, c_pp, c_pv, c_vp, c_vv;
        bit clamped;
        t_estimate estimates[$];
        int errors;
        int checked;
        int skips;
        int sats;

        function new();
            r_meas = 65536;
            q_pp = 0;
            q_pv = 0;
            q_vp = 0;
            q_vv = 0;
            mot_pos = 0;
            mot_vel = 0;
            init_var = 65536000;
            errors = 0;
            checked = 0;
            skips = 0;
            sats = 0;
            reload();
        endfunction

        function void reload();
            pos = 0;
            vel = 0;
            c_pp = init_var;
            c_pv = 0;
            c_vp = 0;
            c_vv = init_var;
        endfunction

        function longint clamp(longint v);
            longint hi;
            hi = 64'sd2147483647;
            if (v > hi) begin
                clamped = 1;
                return hi;
            end
            if (v < -hi - 1) begin
                clamped = 1;
                return -hi - 1;
            end
            return v;
        endfunction

        function longint unsigned mag(longint a);
            return (a < 0) ? longint'(-a) : a;
        endfunction

        function longint qmul(longint a, longint b);
            longint unsigned p;
            p = (mag(a) * mag(b)) >> FB;
            return clamp(((a < 0) != (b < 0)) ? -longint'(p) : longint'(p));
        endfunction

        // Divisor is positive whenever this is called.
        function longint qdiv(longint a, longint b);
            longint unsigned q;
            q = (mag(a) << FB) / longint'(b);
            return clamp((a < 0) ? -longint'(q) : longint'(q));
        endfunction

        function void set_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [WW-1:0] d);
            case (idx)
                REG_MEAS_NOISE: r_meas = longint'(d[30:0]);
                REG_Q_PP:       q_pp = longint'(signed'(d));
                REG_Q_PV:       q_pv = longint'(signed'(d));
                REG_Q_VP:       q_vp = longint'(signed'(d));
                REG_Q_VV:       q_vv = longint'(signed'(d));
                REG_MOTION_POS: mot_pos = longint'(signed'(d));
                REG_MOTION_VEL: mot_vel = longint'(signed'(d));
                REG_INIT_VAR:   init_var = longint'(d[30:0]);
                default: ;
            endcase
        endfunction

        // On each accepted sample: measurement update unless skipped, then prediction.
        function void note_sample(logic [WW-1:0] z_bits, logic restart);
            longint z, s, y, k0, k1, p00, p01, p10, p11;
            bit skipped;
            t_estimate e;
            z = longint'(signed'(z_bits));
            clamped = 0;
            if (restart) reload();
            s = clamp(c_pp + r_meas);
            skipped = (s <= 0);
            if (!skipped) begin
                y = clamp(z - pos);
                k0 = qdiv(c_pp, s);
                k1 = qdiv(c_vp, s);
                p00 = c_pp; p01 = c_pv; p10 = c_vp; p11 = c_vv;
                pos = clamp(pos + qmul(k0, y));
                vel = clamp(vel + qmul(k1, y));
                c_pp = clamp(p00 - qmul(k0, p00));
                c_pv = clamp(p01 - qmul(k0, p01));
                c_vp = clamp(p10 - qmul(k1, p00));
                c_vv = clamp(p11 - qmul(k1, p01));
            end
            p00 = c_pp; p01 = c_pv; p10 = c_vp; p11 = c_vv;
            pos = clamp(pos + vel + mot_pos);
            vel = clamp(vel + mot_vel);
            c_pp = clamp(p00 + p01 + p10 + p11 + q_pp);
            c_pv = clamp(p01 + p11 + q_pv);
            c_vp = clamp(p10 + p11 + q_vp);
            c_vv = clamp(p11 + q_vv);
            e.pos = pos[WW-1:0];
            e.vel = vel[WW-1:0];
            e.pp = c_pp[WW-1:0];
            e.pv = c_pv[WW-1:0];
            e.vp = c_vp[WW-1:0];
            e.vv = c_vv[WW-1:0];
            e.fault = skipped ? FAULT_SKIPPED : (clamped ? FAULT_SAT : FAULT_OK);
            if (skipped) skips++;
            else if (clamped) sats++;
            estimates = {estimates, e};
        endfunction

        function void cmp(string name, logic [WW-1:0] exp_v, logic [WW-1:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v,
                         act_v);
                errors++;
            end
        endfunction

        function void check_result(t_estimate act);
            t_estimate e;
            if (estimates.size() == 0) begin
                $display("%0t: unexpected result transfer, expected none, actual %h",
                         $time, act);
                errors++;
                return;
            end
            e = estimates.pop_front();
            checked++;
            cmp("est_pos", e.pos, act.pos);
            cmp("est_vel", e.vel, act.vel);
            cmp("cov_pp", e.pp, act.pp);
            cmp("cov_pv", e.pv, act.pv);
            cmp("cov_vp", e.vp, act.vp);
            cmp("cov_vv", e.vv, act.vv);
            cmp("fault", WW'(e.fault), WW'(act.fault));
        endfunction
    endclass

    logic                        i_clk = 0;
    logic                        i_rst_n = 0;
    logic                        i_in_valid = 0;
    logic                        o_in_ready;
    logic signed [WW-1:0]        i_measured_pos = '0;
    logic                        i_restart = 0;
    logic                        o_out_valid;
    logic                        i_out_ready = 0;
    logic signed [WW-1:0]        o_est_pos, o_est_vel;
    logic signed [WW-1:0]        o_cov_out_pp, o_cov_out_pv, o_cov_out_vp, o_cov_out_vv;
    logic [1:0]                  o_fault;
    logic                        i_cfg_valid = 0;
    logic                        o_cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0]  i_cfg_index = '0;
    logic [WW-1:0]               i_cfg_data = '0;

    filter_scoreboard sb = new();
    bit quiet = 0;        // when set, neither side idles
    int stall_cycles = 0;
    longint track = 0;    // slowly moving target that the well-formed samples follow

    always #4 i_clk = ~i_clk;

    kalman_filter_const_velocity #(.WORD_WIDTH(WW), .FRAC_BITS(FB)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_measured_pos(i_measured_pos), .i_restart(i_restart),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_est_pos(o_est_pos), .o_est_vel(o_est_vel),
        .o_cov_out_pp(o_cov_out_pp), .o_cov_out_pv(o_cov_out_pv),
        .o_cov_out_vp(o_cov_out_vp), .o_cov_out_vv(o_cov_out_vv),
        .o_fault(o_fault),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    function automatic bit idle_roll();
        return !quiet && ($urandom_range(99) < 12);
    endfunction

    // The result side stalls at random; ready changes only on the falling edge.
    always @(negedge i_clk) begin
        i_out_ready <= !idle_roll();
    end

    // Every output transfer is checked at the rising edge it happens on.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result({o_est_pos, o_est_vel, o_cov_out_pp, o_cov_out_pv,
                             o_cov_out_vp, o_cov_out_vv, o_fault});
        end
    end

    // The watchdog restarts its count on any transfer and fails the run when the
    // block has been silent for far longer than one sample ever takes.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles > STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // One sample transfer; the sample is handed to the scoreboard at its accepting edge.
    task automatic send_sample(logic [WW-1:0] z, logic restart);
        @(negedge i_clk);
        while (idle_roll()) begin
            i_in_valid <= 0;
            @(negedge i_clk);
        end
        i_in_valid <= 1;
        i_measured_pos <= z;
        i_restart <= restart;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_sample(z, restart);
    endtask

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [WW-1:0] d);
        @(negedge i_clk);
        while (idle_roll()) begin
            i_cfg_valid <= 0;
            @(negedge i_clk);
        end
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, d);
    endtask

    // Registers change only once the block is idle: every expected result has been
    // seen, after which a short pause covers any tail of the sequencer.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 0;
        i_cfg_valid <= 0;
        while (sb.estimates.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_all(logic [WW-1:0] r, logic [WW-1:0] qpp, logic [WW-1:0] qpv,
                             logic [WW-1:0] qvp, logic [WW-1:0] qvv, logic [WW-1:0] mp,
                             logic [WW-1:0] mv, logic [WW-1:0] iv);
        drain();
        write_reg(REG_MEAS_NOISE, r);
        write_reg(REG_Q_PP, qpp);
        write_reg(REG_Q_PV, qpv);
        write_reg(REG_Q_VP, qvp);
        write_reg(REG_Q_VV, qvv);
        write_reg(REG_MOTION_POS, mp);
        write_reg(REG_MOTION_VEL, mv);
        write_reg(REG_INIT_VAR, iv);
        // Writes past the last register must not disturb anything.
        write_reg(CFG_INDEX_WIDTH'($urandom_range(REG_FIRST_UNUSED, 15)), $urandom);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    function automatic logic [WW-1:0] small_signed(int unsigned span);
        return WW'($urandom_range(2 * span) - span);
    endfunction

    // Well-formed traffic tracks a moving target with a little noise; a minority of
    // samples are full-range noise or restarts in the middle of a track.
    task automatic random_samples(int n);
        longint step;
        step = longint'(signed'(small_signed(1 << 17)));
        repeat (n) begin
            if ($urandom_range(99) < 15) begin
                send_sample($urandom, 1'($urandom_range(1)));
            end else begin
                track = track + step;
                if (track > 64'sd1000000000 || track < -64'sd1000000000) track = 0;
                send_sample(WW'(track) + small_signed(1 << 15), $urandom_range(99) < 5);
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Default registers: restart, field extremes and a short steady track.
        send_sample('0, 1);
        send_sample(32'h7FFF_FFFF, 0);
        send_sample(32'h8000_0000, 0);
        send_sample(32'h0001_0000, 1);
        send_sample(32'hFFFF_0000, 0);
        for (int k = 0; k < 6; k++) send_sample(WW'(k * 65536), 0);

        // Every register at its maximum, with the unused top bit set on the 31-bit ones:
        // the innovation variance and most sums saturate.
        write_all('1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, '1);
        send_sample(32'h7FFF_FFFF, 1);
        send_sample(32'h8000_0000, 0);
        send_sample('0, 0);

        // Zero noise and zero initial variance: the variance is not positive so the
        // update is skipped; negative process noise keeps it that way.
        write_all('0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, '0);
        send_sample(32'h0012_3456, 1);
        send_sample(32'h7FFF_FFFF, 0);
        send_sample(32'h8000_0000, 0);
        write_all(32'd1, '0, '0, '0, '0, '0, '0, '0);
        send_sample(32'h0001_0000, 1);
        send_sample(32'h0002_0000, 0);

        // Back to defaults with a long stretch of back-to-back traffic.
        write_all(32'd65536, '0, '0, '0, '0, '0, '0, 32'd65536000);
        quiet = 1;
        send_sample('0, 1);
        random_samples(80);
        drain();
        quiet = 0;

        // Random register settings, mostly plausible with an occasional full-range one.
        for (int ph = 0; ph < 5; ph++) begin
            if (ph == 4) begin
                write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom);
            end else begin
                write_all({1'($urandom_range(1)), 31'($urandom_range(1 << 20))},
                          small_signed(1 << 12), small_signed(1 << 10),
                          small_signed(1 << 10), small_signed(1 << 10),
                          small_signed(1 << 14), small_signed(1 << 8),
                          {1'($urandom_range(1)), 31'($urandom_range(1 << 24))});
            end
            send_sample('0, 1);
            random_samples(80);
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);
        $display("Checked %0d estimates over 10 register settings:", sb.checked);
        $display("%0d skipped updates, %0d saturated, %0d mismatches.",
                 sb.skips, sb.sats, sb.errors);
        if (sb.errors == 0 && sb.estimates.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

### filelist.f
hdl/kfcv_pkg.sv
hdl/kfcv_mul.sv
hdl/kfcv_div.sv
hdl/kalman_filter_const_velocity.sv
tb/sv/kalman_filter_const_velocity_tb.sv
